[src/tbg_pkg.sv]
// Shared types, constants and the sine table builder for the tone burst generator.
`timescale 1ns / 1ps
package tbg_pkg;

  localparam int PHASE_W    = 32;
  localparam int INDEX_W    = 22;
  localparam int SAMPLE_W   = 16;
  localparam int AMP_W      = 15;
  localparam int PEAK_AMPL  = 20000;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BURST_LENGTH = 1'd1;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30     = 64'd1 << 30;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [INDEX_W-1:0] idx;
  } tbg_state_t;

  // Q1.15 full-wave sine entry, polynomial evaluated in Q30 at elaboration
  function automatic logic signed [SAMPLE_W-1:0] sine_entry(input int unsigned tbits,
                                                             input int unsigned k);
    longint unsigned qshift;
    longint unsigned quarter;
    longint unsigned q;
    longint unsigned r;
    longint unsigned a;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    longint unsigned m;
    logic signed [SAMPLE_W-1:0] res;
    qshift  = longint'(tbits) - 64'd2;
    quarter = 64'd1 << qshift;
    q       = (longint'(k) >> qshift) & 64'd3;
    r       = longint'(k) & (quarter - 64'd1);
    a       = q[0] ? (quarter - r) : r;
    x       = (a * HALF_PI_Q30) >> qshift;
    x2      = (x * x) >> 30;
    t       = ONE_Q30;
    t       = ONE_Q30 - ((x2 * t) >> 30) / 110;
    t       = ONE_Q30 - ((x2 * t) >> 30) / 72;
    t       = ONE_Q30 - ((x2 * t) >> 30) / 42;
    t       = ONE_Q30 - ((x2 * t) >> 30) / 20;
    t       = ONE_Q30 - ((x2 * t) >> 30) / 6;
    s       = (x * t) >> 30;
    m       = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    if (m > 64'd32767) m = 64'd32767;
    res = SAMPLE_W'(m);
    if (q >= 64'd2) res = -res;
    return res;
  endfunction

endpackage

[src/tone_burst_generator.sv]
// Top level: NCO sine tone burst with linear fade-in and fade-out envelope.
//
//  channel | handshake                  | payload
//  --------+----------------------------+---------------------------------
//  in      | in_valid_i / in_stall_o    | restart_i
//  out     | out_valid_o / out_stall_i  | sample_o, last_o
//  cfg     | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// One transaction per cycle unless stalled; a sample passes stages 1 to 4 and the
// output register. Phase and index live in a one-entry state RAM, read every cycle
// and written on each input transaction; a bypass register hides the registered read.
// After reset a valid flag makes the unwritten state RAM read as zero.
// Each pipeline stage holds when the next one is full and stalled; bubbles collapse.
`timescale 1ns / 1ps
module tone_burst_generator import tbg_pkg::*; #(
  parameter int TABLE_BITS = 10,
  parameter int RAMP_LEN   = 40
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       restart_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [SAMPLE_W-1:0] sample_o,
  output logic                       last_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int EW     = $clog2(RAMP_LEN + 1);
  localparam int GW     = $clog2(RAMP_LEN * PEAK_AMPL + 1);
  localparam int ZW     = $clog2(RAMP_LEN * PEAK_AMPL);
  localparam int SHIFT  = ZW + $clog2(RAMP_LEN);
  localparam int MW     = ZW + 2;
  localparam int PW     = AMP_W + GW;
  localparam int QW     = ZW + MW;
  localparam int STW    = $bits(tbg_state_t);
  localparam logic [MW-1:0] RECIP =
    MW'(((64'd1 << SHIFT) + 64'(RAMP_LEN) - 64'd1) / 64'(RAMP_LEN));

  // configuration
  logic [PHASE_W-1:0] phase_step_q;
  logic [INDEX_W-1:0] burst_len_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q <= '0;
      burst_len_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_PHASE_STEP:   phase_step_q <= cfg_data_i;
        REG_BURST_LENGTH: burst_len_q  <= cfg_data_i[INDEX_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline enables
  logic v1_q, v2_q, v3_q, v4_q, out_v_q;
  logic en1, en2, en3, en4, en_out;
  logic accept;

  assign en_out     = !out_v_q || !out_stall_i;
  assign en4        = !v4_q || en_out;
  assign en3        = !v3_q || en4;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_stall_o = !en1;
  assign accept     = in_valid_i && en1;

  // state RAM with bypass
  logic [STW-1:0] ram_rdata;
  tbg_state_t     st_rd, st_cur, st_new;
  tbg_state_t     byp_q;
  logic           byp_v_q, init_q;

  tbg_ram #(
    .WIDTH(STW),
    .DEPTH(1)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (1'b0),
    .wdata_i (st_new),
    .raddr_i (1'b0),
    .rdata_o (ram_rdata)
  );

  assign st_rd = tbg_state_t'(ram_rdata);

  always_comb begin
    if (!init_q) begin
      st_cur = '0;
    end else if (byp_v_q) begin
      st_cur = byp_q;
    end else begin
      st_cur = st_rd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_v_q <= 1'b0;
      init_q  <= 1'b0;
    end else begin
      byp_v_q <= accept;
      if (accept) init_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) byp_q <= st_new;
  end

  // stage 0: step the state, envelope count
  logic [PHASE_W-1:0] ph0;
  logic [INDEX_W-1:0] i0;
  logic [INDEX_W:0]   i0_inc, i0_ramp;
  logic               active0, last0;
  logic [EW-1:0]      env0;

  always_comb begin
    ph0     = restart_i ? '0 : st_cur.phase;
    i0      = restart_i ? '0 : st_cur.idx;
    active0 = i0 < burst_len_q;
    i0_inc  = {1'b0, i0} + (INDEX_W+1)'(1);
    i0_ramp = {1'b0, i0} + (INDEX_W+1)'(RAMP_LEN);
    last0   = i0_inc == {1'b0, burst_len_q};
    if (i0_ramp > {1'b0, burst_len_q}) begin
      env0 = EW'(burst_len_q - i0);
    end else if (i0 < INDEX_W'(RAMP_LEN)) begin
      env0 = EW'(i0);
    end else begin
      env0 = EW'(RAMP_LEN);
    end
    if (active0) begin
      st_new.phase = ph0 + phase_step_q;
      st_new.idx   = i0_inc[INDEX_W-1:0];
    end else begin
      st_new.phase = ph0;
      st_new.idx   = i0;
    end
  end

  // stage 1
  logic [TABLE_BITS-1:0] k1_q;
  logic [EW-1:0]         env1_q;
  logic                  last1_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      k1_q    <= ph0[PHASE_W-1 -: TABLE_BITS];
      env1_q  <= env0;
      last1_q <= last0;
    end
  end

  // stage 2: sine lookup, envelope gain
  logic signed [SAMPLE_W-1:0] sine2;
  logic [GW-1:0]              g2_q;
  logic                       last2_q;

  tbg_sine_rom #(
    .TABLE_BITS(TABLE_BITS)
  ) u_sine_rom (
    .clk_i  (clk_i),
    .en_i   (en2),
    .addr_i (k1_q),
    .data_o (sine2)
  );

  always_ff @(posedge clk_i) begin
    if (en2) begin
      g2_q    <= GW'(env1_q) * GW'(PEAK_AMPL);
      last2_q <= last1_q;
    end
  end

  // stage 3: |sine| * gain, drop Q15 fraction
  logic [SAMPLE_W-1:0] abs3;
  logic [PW-1:0]       prod3;
  logic [ZW-1:0]       z3_q;
  logic                neg3_q, last3_q;

  assign abs3  = sine2[SAMPLE_W-1] ? SAMPLE_W'(-sine2) : SAMPLE_W'(sine2);
  assign prod3 = PW'(abs3[AMP_W-1:0]) * PW'(g2_q);

  always_ff @(posedge clk_i) begin
    if (en3) begin
      z3_q    <= ZW'(prod3 >> 15);
      neg3_q  <= sine2[SAMPLE_W-1];
      last3_q <= last2_q;
    end
  end

  // stage 4: exact divide by the ramp length via reciprocal
  logic [QW-1:0]    prod4;
  logic [AMP_W-1:0] amp4_q;
  logic             neg4_q, last4_q;

  assign prod4 = QW'(z3_q) * QW'(RECIP);

  always_ff @(posedge clk_i) begin
    if (en4) begin
      amp4_q  <= AMP_W'(prod4 >> SHIFT);
      neg4_q  <= neg3_q;
      last4_q <= last3_q;
    end
  end

  // output register
  logic [SAMPLE_W-1:0] sample_d, sample_q;
  logic                last_q;

  assign sample_d = neg4_q ? (SAMPLE_W'(0) - {1'b0, amp4_q}) : {1'b0, amp4_q};

  always_ff @(posedge clk_i) begin
    if (en_out) begin
      sample_q <= sample_d;
      last_q   <= last4_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (en1)    v1_q    <= accept && active0;
      if (en2)    v2_q    <= v1_q;
      if (en3)    v3_q    <= v2_q;
      if (en4)    v4_q    <= v3_q;
      if (en_out) out_v_q <= v4_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign sample_o    = sample_q;
  assign last_o      = last_q;

endmodule

[src/tbg_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module tbg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/tbg_sine_rom.sv]
// Full-wave Q1.15 sine table with registered read.
`timescale 1ns / 1ps
module tbg_sine_rom import tbg_pkg::*; #(
  parameter int TABLE_BITS = 10
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [TABLE_BITS-1:0]      addr_i,
  output logic signed [SAMPLE_W-1:0] data_o
);

  localparam int DEPTH = 1 << TABLE_BITS;

  logic signed [SAMPLE_W-1:0] tab [DEPTH];
  logic signed [SAMPLE_W-1:0] data_q;

  for (genvar g = 0; g < DEPTH; g++) begin : g_tab
    assign tab[g] = sine_entry(TABLE_BITS, g);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= tab[addr_i];
    end
  end

  assign data_o = data_q;

endmodule
